// ===== src/vpa_pkg.sv =====
// Shared types and codes of the variable partition allocator.
`default_nettype none

package vpa_pkg;

    // One partition table entry, start address in the lowest bits.
    typedef struct packed {
        logic [7:0]  owner;
        logic        free;
        logic [15:0] length;
        logic [15:0] start;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_NOOWNER = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Request kinds.
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Register selection, taken from paddr bit 2.
    localparam logic REG_FIT   = 1'b0;
    localparam logic REG_TOTAL = 1'b1;

    localparam logic [15:0] TOTAL_RESET = 16'd640;

endpackage

`default_nettype wire

// ===== src/variable_partition_allocator.sv =====
// Top level of the variable partition allocator: sequencer, table memory and ports.
// One request is taken at a time. The search stops at the first fit, or at the owner on a
// release; in best-fit mode an allocation reads the whole table. A split moves the entries
// above the pick up by one, and a release rewrites the table to merge free neighbours. The
// result is offered in the same cycle as the port reopens. Reset (synchronous, active low)
// restores the register defaults and writes entry 0.
`default_nettype none

module variable_partition_allocator #(
    parameter int MAX_PARTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // job_id[7:0], request_size[23:8]
    input  wire logic [0:0]  s_axis_tuser,  // action[0]
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,  // granted_start[15:0], granted_size[31:16]
    output logic      [1:0]  m_axis_tuser,  // status[1:0]
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    import vpa_pkg::*;

    localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CW = $clog2(MAX_PARTS + 1);

    // One-hot sequencer states.
    typedef enum logic [8:0] {
        S_INIT     = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_SCAN     = 9'b000000100,
        S_DECIDE   = 9'b000001000,
        S_SHIFT    = 9'b000010000,
        S_PLACE_LO = 9'b000100000,
        S_PLACE    = 9'b001000000,
        S_COMPACT  = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers and table fill count.
    logic          r_fit, n_fit;
    logic [15:0]   r_total, n_total;
    logic [CW-1:0] r_count, n_count;

    // Captured request.
    logic        r_act, n_act;
    logic [7:0]  r_job, n_job;
    logic [15:0] r_size, n_size;

    // Walk pointers: r_ri is the next read (or, while shifting, the destination),
    // r_dv/r_di tag the entry arriving from the memory this cycle.
    logic [CW-1:0] r_ri, n_ri;
    logic          r_dv, n_dv;
    logic [IW-1:0] r_di, n_di;

    // Chosen entry.
    logic          r_found, n_found;
    logic [IW-1:0] r_pick, n_pick;
    logic [15:0]   r_pk_start, n_pk_start;
    logic [15:0]   r_pk_len, n_pk_len;

    // Compaction accumulator and write pointer.
    t_entry        r_acc, n_acc;
    logic          r_acc_v, n_acc_v;
    logic [IW-1:0] r_wj, n_wj;

    // Result waiting to be handed to the output register.
    logic [1:0]  r_res_st, n_res_st;
    logic [15:0] r_res_start, n_res_start;
    logic [15:0] r_res_size, n_res_size;

    // Output register.
    logic        r_m_valid, n_m_valid;
    logic [31:0] r_m_tdata, n_m_tdata;
    logic [1:0]  r_m_tuser, n_m_tuser;

    // Table memory port.
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    t_entry             ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rbits;
    t_entry             ram_rdata;

    logic          cfg_wr;
    logic          s_accept;
    logic          issue;
    logic          fits;
    logic [CW-1:0] pick1;
    t_entry        ent;

    assign ram_rdata     = t_entry'(ram_rbits);
    assign cfg_wr        = psel && penable && pwrite;
    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;
    assign pick1         = CW'(r_pick) + CW'(1);

    // Register read-back; the low address bits are not decoded.
    always_comb begin
        if (paddr[2] == REG_TOTAL) begin
            prdata = {16'd0, r_total};
        end else begin
            prdata = {31'd0, r_fit};
        end
    end

    vpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PARTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    always_comb begin
        n_state     = r_state;
        n_fit       = r_fit;
        n_total     = r_total;
        n_count     = r_count;
        n_act       = r_act;
        n_job       = r_job;
        n_size      = r_size;
        n_ri        = r_ri;
        n_dv        = 1'b0;
        n_di        = r_di;
        n_found     = r_found;
        n_pick      = r_pick;
        n_pk_start  = r_pk_start;
        n_pk_len    = r_pk_len;
        n_acc       = r_acc;
        n_acc_v     = r_acc_v;
        n_wj        = r_wj;
        n_res_st    = r_res_st;
        n_res_start = r_res_start;
        n_res_size  = r_res_size;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_m_tdata   = r_m_tdata;
        n_m_tuser   = r_m_tuser;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = r_ri[IW-1:0];
        issue       = 1'b0;
        fits        = 1'b0;
        ent         = ram_rdata;

        unique case (r_state)
            S_INIT: begin
                // Lay down the single free partition that spans the whole memory.
                ram_we           = 1'b1;
                ram_wdata.length = r_total;
                ram_wdata.free   = 1'b1;
                n_state          = S_IDLE;
            end

            S_IDLE: begin
                if (s_accept) begin
                    n_act   = s_axis_tuser[0];
                    n_job   = s_axis_tdata[7:0];
                    n_size  = s_axis_tdata[23:8];
                    n_ri    = '0;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end
            end

            S_SCAN: begin
                // Reads are issued one a cycle and judged when the data returns.
                issue = (r_ri < r_count);
                if (issue) begin
                    n_ri = r_ri + CW'(1);
                    n_dv = 1'b1;
                    n_di = r_ri[IW-1:0];
                end
                if (r_dv) begin
                    if (r_act == ACT_ALLOC) begin
                        fits = ent.free && (ent.length >= r_size);
                        if (fits && (!r_found || (r_fit && (ent.length < r_pk_len)))) begin
                            n_found    = 1'b1;
                            n_pick     = r_di;
                            n_pk_start = ent.start;
                            n_pk_len   = ent.length;
                        end
                        if (fits && !r_fit) begin
                            n_state = S_DECIDE;
                        end
                    end else if (!ent.free && (ent.owner == r_job)) begin
                        n_found    = 1'b1;
                        n_pick     = r_di;
                        n_pk_start = ent.start;
                        n_pk_len   = ent.length;
                        n_state    = S_DECIDE;
                    end
                end
                if (!issue && !r_dv) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_res_st    = ST_OK;
                n_res_start = '0;
                n_res_size  = '0;
                if (r_act == ACT_ALLOC) begin
                    if ((r_size == 16'd0) || !r_found) begin
                        n_res_st = ST_NOFIT;
                        n_state  = S_DONE;
                    end else if (r_pk_len > r_size) begin
                        if (r_count >= CW'(MAX_PARTS)) begin
                            n_res_st = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_ri    = r_count;
                            n_state = S_SHIFT;
                        end
                    end else begin
                        n_state = S_PLACE;
                    end
                end else if (!r_found) begin
                    n_res_st = ST_NOOWNER;
                    n_state  = S_DONE;
                end else begin
                    n_res_start = r_pk_start;
                    n_res_size  = r_pk_len;
                    n_ri        = '0;
                    n_acc_v     = 1'b0;
                    n_wj        = '0;
                    n_state     = S_COMPACT;
                end
            end

            S_SHIFT: begin
                // Move entries above the pick up by one, highest first.
                issue = (r_ri > pick1);
                if (issue) begin
                    ram_raddr = IW'(r_ri - CW'(1));
                    n_ri      = r_ri - CW'(1);
                    n_dv      = 1'b1;
                    n_di      = r_ri[IW-1:0];
                end
                if (r_dv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_di;
                    ram_wdata = ram_rdata;
                end
                if (!issue && !r_dv) begin
                    n_state = S_PLACE_LO;
                end
            end

            S_PLACE_LO: begin
                // The remainder becomes a free partition right after the grant.
                ram_we           = 1'b1;
                ram_waddr        = r_pick + IW'(1);
                ram_wdata.start  = r_pk_start + r_size;
                ram_wdata.length = r_pk_len - r_size;
                ram_wdata.free   = 1'b1;
                n_count          = r_count + CW'(1);
                n_state          = S_PLACE;
            end

            S_PLACE: begin
                ram_we           = 1'b1;
                ram_waddr        = r_pick;
                ram_wdata.start  = r_pk_start;
                ram_wdata.length = r_size;
                ram_wdata.owner  = r_job;
                n_res_st         = ST_OK;
                n_res_start      = r_pk_start;
                n_res_size       = r_size;
                n_state          = S_DONE;
            end

            S_COMPACT: begin
                // Rewrite the table in place, freeing the released entry on the fly
                // and folding every run of free neighbours into its first entry.
                issue = (r_ri < r_count);
                if (issue) begin
                    n_ri = r_ri + CW'(1);
                    n_dv = 1'b1;
                    n_di = r_ri[IW-1:0];
                end
                if (r_dv) begin
                    if (r_di == r_pick) begin
                        ent.free  = 1'b1;
                        ent.owner = '0;
                    end
                    if (!r_acc_v) begin
                        n_acc   = ent;
                        n_acc_v = 1'b1;
                    end else if (r_acc.free && ent.free) begin
                        n_acc.length = r_acc.length + ent.length;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_wj;
                        ram_wdata = r_acc;
                        n_wj      = r_wj + IW'(1);
                        n_acc     = ent;
                    end
                end
                if (!issue && !r_dv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wj;
                    ram_wdata = r_acc;
                    n_count   = CW'(r_wj) + CW'(1);
                    n_state   = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_tdata = {r_res_size, r_res_start};
                    n_m_tuser = r_res_st;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_INIT;
            end
        endcase

        // Register writes must arrive only while the sequencer is idle; the block does not enforce this.
        if (cfg_wr) begin
            if (paddr[2] == REG_TOTAL) begin
                n_total          = pwdata[15:0];
                n_count          = CW'(1);
                ram_we           = 1'b1;
                ram_waddr        = '0;
                ram_wdata        = '0;
                ram_wdata.length = pwdata[15:0];
                ram_wdata.free   = 1'b1;
            end else begin
                n_fit = pwdata[0];
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_fit     <= 1'b0;
            r_total   <= TOTAL_RESET;
            r_count   <= CW'(1);
            r_dv      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fit     <= n_fit;
            r_total   <= n_total;
            r_count   <= n_count;
            r_dv      <= n_dv;
            r_m_valid <= n_m_valid;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_act       <= n_act;
        r_job       <= n_job;
        r_size      <= n_size;
        r_ri        <= n_ri;
        r_di        <= n_di;
        r_found     <= n_found;
        r_pick      <= n_pick;
        r_pk_start  <= n_pk_start;
        r_pk_len    <= n_pk_len;
        r_acc       <= n_acc;
        r_acc_v     <= n_acc_v;
        r_wj        <= n_wj;
        r_res_st    <= n_res_st;
        r_res_start <= n_res_start;
        r_res_size  <= n_res_size;
        r_m_tdata   <= n_m_tdata;
        r_m_tuser   <= n_m_tuser;
    end

    // The table always holds at least one and at most MAX_PARTS partitions.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CW'(MAX_PARTS)))
        else $error("partition count out of range");

    // A failed request reports zero start and size.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == 32'd0))
        else $error("failure result carries non-zero fields");

    // Compaction never writes ahead of the entry being read.
    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_COMPACT) && r_dv) |-> (r_wj <= r_di))
        else $error("compaction write pointer overtook read pointer");

    // The search pass leaves the table untouched.
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && !cfg_wr) |-> !ram_we)
        else $error("table written during search");

    // One request at a time: after a transaction is taken the port closes.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !s_axis_tready)
        else $error("request accepted while busy");

endmodule

`default_nettype wire

// ===== src/vpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module vpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the variable partition allocator: directed table, random phases.
module tb_top;
    import vpa_pkg::*;

    // The table depth matches the default of the block. The quiet limit is several times
    // the longest correct gap between transactions, which is the long receiver hold-off.
    localparam int NPARTS       = 16;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [2:0] ADDR_FIT   = {REG_FIT, 2'b00};
    localparam logic [2:0] ADDR_TOTAL = {REG_TOTAL, 2'b00};

    // One result of the block, in the order status, start, size.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] start;
        logic [15:0] size;
    } grant_t;

    // One row of the directed table. Where typed is set, the expected grant is taken
    // from the row instead of from the partition predictor.
    typedef struct {
        logic        act;
        logic [7:0]  job;
        logic [15:0] size;
        bit          typed;
        grant_t      want;
    } req_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // job_id[7:0], request_size[23:8]
    logic [0:0]  s_axis_tuser;   // action[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // granted_start[15:0], granted_size[31:16]
    logic [1:0]  m_axis_tuser;   // status[1:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    variable_partition_allocator #(
        .MAX_PARTS(NPARTS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow copy of the partition table and of the two registers.
    logic [15:0] tbl_start [NPARTS];
    logic [15:0] tbl_len   [NPARTS];
    logic        tbl_free  [NPARTS];
    logic [7:0]  tbl_owner [NPARTS];
    int          tbl_count;
    logic        fit_smallest;
    logic [15:0] pool_kb;

    grant_t      pending_grants [$];
    req_row_t    directed_rows [$];

    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    bit          hold_req;
    int          errors;
    int          quiet_cycles;
    int          n_alloc;
    int          n_release;
    int          n_settings;
    int          seen_status [4];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Writing total_kb, like reset, leaves one free partition covering the whole pool.
    function automatic void table_restart();
        int k;
        for (k = 0; k < NPARTS; k++) begin
            tbl_start[k] = '0;
            tbl_len[k]   = '0;
            tbl_free[k]  = 1'b0;
            tbl_owner[k] = '0;
        end
        tbl_len[0]  = pool_kb;
        tbl_free[0] = 1'b1;
        tbl_count   = 1;
    endfunction

    // Closes the gap left by entry idx by moving every later entry down one place.
    function automatic void drop_entry(int idx);
        int k;
        for (k = idx; k + 1 < tbl_count; k++) begin
            tbl_start[k] = tbl_start[k + 1];
            tbl_len[k]   = tbl_len[k + 1];
            tbl_free[k]  = tbl_free[k + 1];
            tbl_owner[k] = tbl_owner[k + 1];
        end
        tbl_count--;
    endfunction

    // Works out the grant for one request and updates the shadow table accordingly.
    function automatic grant_t predict_grant(logic act, logic [7:0] job, logic [15:0] sz);
        grant_t r;
        bit     found;
        int     pick;
        int     k;
        r     = '0;
        found = 1'b0;
        pick  = 0;
        if (act == ACT_ALLOC) begin
            r.status = ST_NOFIT;
            if (sz != 16'd0) begin
                for (k = 0; k < tbl_count; k++) begin
                    if (tbl_free[k] && tbl_len[k] >= sz) begin
                        // Best fit keeps the earliest of equally small partitions.
                        if (!found || (fit_smallest && tbl_len[k] < tbl_len[pick])) begin
                            pick  = k;
                            found = 1'b1;
                        end
                        if (!fit_smallest) break;
                    end
                end
            end
            if (found && tbl_len[pick] > sz && tbl_count >= NPARTS) begin
                // A remainder has to be split off but there is no entry left for it.
                r.status = ST_FULL;
            end else if (found) begin
                if (tbl_len[pick] > sz) begin
                    for (k = tbl_count; k > pick + 1; k--) begin
                        tbl_start[k] = tbl_start[k - 1];
                        tbl_len[k]   = tbl_len[k - 1];
                        tbl_free[k]  = tbl_free[k - 1];
                        tbl_owner[k] = tbl_owner[k - 1];
                    end
                    tbl_start[pick + 1] = tbl_start[pick] + sz;
                    tbl_len[pick + 1]   = tbl_len[pick] - sz;
                    tbl_free[pick + 1]  = 1'b1;
                    tbl_owner[pick + 1] = '0;
                    tbl_count++;
                end
                tbl_len[pick]   = sz;
                tbl_free[pick]  = 1'b0;
                tbl_owner[pick] = job;
                r = '{status: ST_OK, start: tbl_start[pick], size: sz};
            end
        end else begin
            r.status = ST_NOOWNER;
            for (k = 0; k < tbl_count && !found; k++) begin
                if (!tbl_free[k] && tbl_owner[k] == job) begin
                    found = 1'b1;
                    r = '{status: ST_OK, start: tbl_start[k], size: tbl_len[k]};
                    tbl_free[k]  = 1'b1;
                    tbl_owner[k] = '0;
                end
            end
            if (found) begin
                // Every run of neighbouring free partitions collapses into its first entry.
                k = 0;
                while (k + 1 < tbl_count) begin
                    if (tbl_free[k] && tbl_free[k + 1]) begin
                        tbl_len[k] = tbl_len[k] + tbl_len[k + 1];
                        drop_entry(k + 1);
                    end else begin
                        k++;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic add_row(input logic act, input logic [7:0] job, input logic [15:0] sz,
                           input bit typed, input logic [1:0] st, input logic [15:0] start,
                           input logic [15:0] len);
        req_row_t row;
        row.act   = act;
        row.job   = job;
        row.size  = sz;
        row.typed = typed;
        row.want  = '{status: st, start: start, size: len};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Offers one request and waits for its transaction. With drain set, the sender first
    // drops tvalid and waits until every outstanding grant has come back.
    task automatic send_req(input logic act, input logic [7:0] job, input logic [15:0] sz,
                            input bit drain, input bit typed, input grant_t typed_res);
        grant_t pred;
        if (drain || $urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while (drain && pending_grants.size() != 0) @(posedge i_clk);
            while ($urandom_range(0, 99) < send_gap_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sz, job};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = predict_grant(act, job, sz);
        pending_grants.insert(pending_grants.size(), typed ? typed_res : pred);
        if (act == ACT_ALLOC) n_alloc++;
        else n_release++;
    endtask

    // Writes one register through a setup and an access cycle, then reads it back.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_FIT) begin
            fit_smallest = val[0];
        end else if (addr == ADDR_TOTAL) begin
            pool_kb = val[15:0];
            table_restart();
        end
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== val) begin
            errors++;
            $display("%0t: register read at %0d: expected %h, actual %h",
                     $time, addr, val, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Brings the block to rest: nothing offered, every grant back, and the latency let pass.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One random phase under a fresh register setting.
    task automatic run_phase(input logic fit, input logic [15:0] kb, input int n,
                             input int unsigned sgap, input int unsigned rstall,
                             input bit hold, input int drain_at);
        int          i;
        int unsigned pick;
        int unsigned cap;
        logic        act;
        logic [7:0]  job;
        logic [15:0] sz;
        settle();
        write_reg(ADDR_FIT, {31'd0, fit});
        write_reg(ADDR_TOTAL, {16'd0, kb});
        n_settings++;
        send_gap_pct   = sgap;
        recv_stall_pct = rstall;
        if (hold) hold_req = 1'b1;
        // Most sizes are a small share of the pool, so that the table fills and splits.
        cap = (kb / 6 > 1) ? kb / 6 : 1;
        for (i = 0; i < n; i++) begin
            // A small pool of job ids makes releases find their owners most of the time.
            job  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 11));
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 40) begin
                act = ACT_RELEASE;
                sz  = 16'($urandom_range(0, 65535));
            end else begin
                act = ACT_ALLOC;
                if (pick < 3) sz = 16'd0;
                else if (pick < 10) sz = 16'($urandom_range(1, 65535));
                else sz = 16'($urandom_range(1, cap));
            end
            send_req(act, job, sz, i == drain_at, 1'b0, '0);
        end
    endtask

    // The receiver stalls at random, except for one long hold-off on request, during which
    // the sender goes on offering and the block has to stall its input.
    initial begin
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    // Every result transaction is compared with the oldest expected grant.
    always @(posedge i_clk) begin : grant_check
        grant_t got;
        grant_t want;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]};
            if (!$isunknown(got.status)) seen_status[got.status]++;
            if (pending_grants.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: actual %h", $time, got);
            end else begin
                want = pending_grants.pop_front();
                if (got.status !== want.status) begin
                    errors++;
                    $display("%0t: status: expected %0d, actual %0d",
                             $time, want.status, got.status);
                end
                if (got.start !== want.start) begin
                    errors++;
                    $display("%0t: granted_start: expected %0d, actual %0d",
                             $time, want.start, got.start);
                end
                if (got.size !== want.size) begin
                    errors++;
                    $display("%0t: granted_size: expected %0d, actual %0d",
                             $time, want.size, got.size);
                end
            end
        end
    end

    // Ends the run if no transaction has been seen on either stream for too long.
    initial begin
        @(posedge i_clk);
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        int i;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_rst_n       <= 1'b0;
        hold_req       = 1'b0;
        errors         = 0;
        n_alloc        = 0;
        n_release      = 0;
        n_settings     = 1;
        for (i = 0; i < 4; i++) seen_status[i] = 0;
        fit_smallest = 1'b0;
        pool_kb      = TOTAL_RESET;
        table_restart();
        send_gap_pct   = 26;
        recv_stall_pct = 69;

        // Directed table, run on the reset setting: first fit over 640.
        add_row(ACT_ALLOC,   8'd0,   16'd0,     1'b1, ST_NOFIT,   16'd0,   16'd0);
        add_row(ACT_ALLOC,   8'd255, 16'd65535, 1'b1, ST_NOFIT,   16'd0,   16'd0);
        add_row(ACT_RELEASE, 8'd128, 16'd65535, 1'b1, ST_NOOWNER, 16'd0,   16'd0);
        add_row(ACT_ALLOC,   8'd255, 16'd100,   1'b1, ST_OK,      16'd0,   16'd100);
        // An exact fit of the remainder needs no split.
        add_row(ACT_ALLOC,   8'd0,   16'd540,   1'b1, ST_OK,      16'd100, 16'd540);
        add_row(ACT_RELEASE, 8'd255, 16'd0,     1'b1, ST_OK,      16'd0,   16'd100);
        // This release leaves two free neighbours, which are merged back into one.
        add_row(ACT_RELEASE, 8'd0,   16'd0,     1'b1, ST_OK,      16'd100, 16'd540);
        add_row(ACT_ALLOC,   8'd1,   16'd640,   1'b1, ST_OK,      16'd0,   16'd640);
        add_row(ACT_RELEASE, 8'd1,   16'd0,     1'b1, ST_OK,      16'd0,   16'd640);
        // Fifteen splits take the table to all sixteen entries.
        for (i = 0; i < 15; i++)
            add_row(ACT_ALLOC, 8'(10 + i), 16'(i + 1), 1'b0, ST_OK, 16'd0, 16'd0);
        // A further split fails on the full table, while an exact fit still succeeds.
        add_row(ACT_ALLOC,   8'd77,  16'd1,     1'b1, ST_FULL,    16'd0,   16'd0);
        add_row(ACT_ALLOC,   8'd78,  16'd520,   1'b0, ST_OK,      16'd0,   16'd0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_req(directed_rows[i].act, directed_rows[i].job, directed_rows[i].size,
                     1'b0, directed_rows[i].typed, directed_rows[i].want);

        // Random phases: the sender idles lightly first, then heavily, then not at all.
        run_phase(1'b1, 16'd65535, 450, 26, 69, 1'b0, -1);
        run_phase(1'b0, 16'd1,     40,  26, 69, 1'b0, -1);
        // With an empty pool every allocate finds no room.
        run_phase(1'b1, 16'd0,     20,  69, 26, 1'b0, -1);
        run_phase(1'b0, 16'd4096,  450, 69, 26, 1'b0, 200);
        run_phase(1'b1, 16'd640,   500, 0,  0,  1'b1, -1);
        run_phase(1'b0, 16'd65535, 490, 0,  0,  1'b0, -1);
        settle();

        $display("Ran %0d allocates and %0d releases under %0d register settings,",
                 n_alloc, n_release, n_settings);
        $display("giving %0d ok, %0d no room, %0d unknown owner and %0d table full.",
                 seen_status[ST_OK], seen_status[ST_NOFIT], seen_status[ST_NOOWNER],
                 seen_status[ST_FULL]);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
